FILE: rtl/pia_pkg.sv
// Package for the positional insert array: word types, operation and
// status codes, and configuration register constants.
// Depends on nothing; imported by every module of the block.
package pia_pkg;

  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_INSERT  = 2'd1,
    KIND_DISPLAY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERR   = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE    = 1'b0,
    S_DISPLAY = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         position;
    logic signed [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               is_last;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_single;   // load a one-word result with single_status
    status_e single_status;
    logic    write_elem;    // store item_value and bump the count
    logic    is_insert;     // write at position instead of at the count
    logic    idx_clr;       // restart the display pointer
    logic    show_elem;     // load the element under the pointer, advance
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic can_append;
    logic can_insert;
    logic count_zero;
    logic last_elem;
  } dp_status_t;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CapW     = 6;

  localparam logic [CfgAddrW-1:0] ADDR_CAPACITY  = 3'd0;
  localparam logic [CapW-1:0]     CAPACITY_RESET = 6'd32;

endpackage

FILE: rtl/pia_ctrl.sv
// Controller of the positional insert array: idle/display state machine.
// Depends on pia_pkg; drives the datapath by ctrl_cmd_t, reads dp_status_t.
module pia_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  pia_pkg::dp_status_t status_i,
  output pia_pkg::ctrl_cmd_t  cmd_o
);
  import pia_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = !((state_q == S_IDLE) && status_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (kind_e'(kind_i) == KIND_DISPLAY) && !status_i.count_zero) begin
          state_d = S_DISPLAY;
        end
      end
      S_DISPLAY: begin
        if (status_i.out_free && status_i.last_elem) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '{load_single: 1'b0, single_status: ST_OK, write_elem: 1'b0,
              is_insert: 1'b0, idx_clr: 1'b0, show_elem: 1'b0};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind_e'(kind_i))
            KIND_APPEND: begin
              cmd_o.load_single   = 1'b1;
              cmd_o.single_status = status_i.can_append ? ST_OK : ST_ERR;
              cmd_o.write_elem    = status_i.can_append;
            end
            KIND_INSERT: begin
              cmd_o.load_single   = 1'b1;
              cmd_o.single_status = status_i.can_insert ? ST_OK : ST_ERR;
              cmd_o.write_elem    = status_i.can_insert;
              cmd_o.is_insert     = 1'b1;
            end
            KIND_DISPLAY: begin
              if (status_i.count_zero) begin
                cmd_o.load_single   = 1'b1;
                cmd_o.single_status = ST_EMPTY;
              end else begin
                cmd_o.idx_clr = 1'b1;
              end
            end
            default: begin
              cmd_o.load_single   = 1'b1;
              cmd_o.single_status = ST_ERR;
            end
          endcase
        end
      end
      S_DISPLAY: begin
        cmd_o.show_elem = status_i.out_free;
      end
      default: ;
    endcase
  end

  a_disp_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DISPLAY) |-> in_stall_o)
    else $error("input taken during display");

  a_single_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_single || cmd_o.write_elem) |-> (accept && state_q == S_IDLE))
    else $error("single result without an accepted word");

  a_show_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.show_elem |-> (status_i.out_free && state_q == S_DISPLAY))
    else $error("element shown without output room");

endmodule

FILE: rtl/pia_datapath.sv
// Datapath of the positional insert array: element cells that shift on
// insert, element count, display pointer and output register.
// Depends on pia_pkg; commanded by pia_ctrl.
module pia_datapath #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pia_pkg::ctrl_cmd_t    cmd_i,
  input  pia_pkg::in_word_t     in_word_i,
  input  logic [pia_pkg::CapW-1:0] capacity_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output pia_pkg::out_word_t    out_word_o,
  output pia_pkg::dp_status_t   status_o
);
  import pia_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  logic signed [31:0] cells_q [DEPTH];
  logic [CntW-1:0]    count_q, count_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_word_q, out_word_d;

  logic [CmpW-1:0] count_w, cap_w, eff_cap, pos_w, wpos;

  assign count_w = CmpW'(count_q);
  assign cap_w   = CmpW'(capacity_i);
  assign pos_w   = CmpW'(in_word_i.position);
  assign eff_cap = (cap_w > CmpW'(DEPTH)) ? CmpW'(DEPTH) : cap_w;
  assign wpos    = cmd_i.is_insert ? pos_w : count_w;

  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.can_append = count_w < eff_cap;
  assign status_o.can_insert = (count_w < eff_cap) && (pos_w <= count_w);
  assign status_o.count_zero = (count_q == '0);
  assign status_o.last_elem  = ((CmpW'(idx_q) + CmpW'(1)) == count_w);

  // Element cells: write at wpos, move cells above it up by one
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.write_elem) begin
        if (CmpW'(i) == wpos) begin
          cells_q[i] <= in_word_i.item_value;
        end else if (i > 0 && CmpW'(i) > wpos && CmpW'(i) <= count_w) begin
          cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.write_elem) begin
      count_d = count_q + CntW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.show_elem) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  // Output register: load a new word, else drop the taken one, else hold
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    if (cmd_i.load_single) begin
      out_valid_d        = 1'b1;
      out_word_d.status  = cmd_i.single_status;
      out_word_d.element = '0;
      out_word_d.is_last = 1'b1;
    end else if (cmd_i.show_elem) begin
      out_valid_d        = 1'b1;
      out_word_d.status  = ST_OK;
      out_word_d.element = cells_q[idx_q];
      out_word_d.is_last = status_o.last_elem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CmpW'(count_q) <= CmpW'(DEPTH))
    else $error("element count above depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(cmd_i.write_elem))
    else $error("count changed without a write");

  a_show_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.show_elem |-> (CmpW'(idx_q) < count_w))
    else $error("display pointer past the count");

endmodule

FILE: rtl/positional_insert_array.sv
// Top level of the positional insert array: capacity register on an APB-style
// port, controller and datapath. Depends on pia_pkg, pia_ctrl, pia_datapath.
//
// Usage: each input word carries one operation (append, insert at position,
// display). Append and insert each return one status word (ok or error) with
// is_last set; an insert shifts every later element up by one in the same
// cycle. A display returns every held element in order, one word per cycle,
// the final one marked is_last, or a single empty status if nothing is held.
// An input word is taken when in_valid_i is high and in_stall_o is low; a
// result word leaves when out_valid_o is high and out_stall_i is low.
// Append, insert, an empty display and an unused kind have their result word
// registered the cycle after accept; one word per cycle while unstalled.
// A display of n elements first restarts the display pointer in the accept
// cycle, then one element per cycle, while the receiver does not stall, goes
// through the single output register. The block takes no input during the
// display; it returns to idle as the last element is loaded, and takes
// input again from idle.
// While the receiver stalls, the output register holds its word and the
// block stops taking input. Reset clears the count (store empty), the
// display state and the output valid flag; the capacity register resets to
// 32. Write capacity only while the block is idle.
module positional_insert_array #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  pia_pkg::in_word_t                in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output pia_pkg::out_word_t               out_word_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pia_pkg::CfgAddrW-1:0]     paddr,
  input  logic [pia_pkg::CfgDataW-1:0]     pwdata,
  output logic [pia_pkg::CfgDataW-1:0]     prdata,
  output logic                             pready
);
  import pia_pkg::*;

  logic [CapW-1:0] capacity_q, capacity_d;
  ctrl_cmd_t       cmd;
  dp_status_t      dp_status;

  // Capacity register: one write per access phase, zero-wait
  assign pready = 1'b1;

  always_comb begin
    capacity_d = capacity_q;
    if (psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY)) begin
      capacity_d = pwdata[CapW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  assign prdata = (paddr == ADDR_CAPACITY) ? CfgDataW'(capacity_q) : '0;

  // Sequencing: idle takes words, display streams elements
  pia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (in_word_i.kind),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // Storage, count, pointer and the output register
  pia_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .capacity_i  (capacity_q),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .status_o    (dp_status)
  );

endmodule
